// ===== hw/rtl/grbf_pkg.sv =====
// ----------------------------------------------------------------------------
// grbf_pkg
// Shared types and constants for the Gaussian radial basis activation block.
// ----------------------------------------------------------------------------
package grbf_pkg;

  // Default fraction width of the Q8.n inputs and of the distance sum
  localparam int FRAC_BITS_DEF = 16;

  localparam int FIELD_W = 24;
  localparam int SUM_W   = 48;
  localparam int ACT_W   = 17;

  // Two quotient bits per divider cycle over a 48-bit dividend
  localparam int DIV_STEPS = SUM_W / 2;
  localparam int SQUARINGS = 8;
  localparam int CTR_W     = $clog2(DIV_STEPS);

  // floor(n/3) = (n * RECIP3) >> RECIP_SHIFT, exact for n < 2^19
  localparam logic [31:0] RECIP3      = 32'd349526;
  localparam int          RECIP_SHIFT = 20;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [ACT_W-1:0] ONE_OUT = 17'd65536;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_value;
    logic signed [FIELD_W-1:0] center_value;
    logic        [FIELD_W-1:0] variance;
    logic                      last_dim;
  } grbf_in_t;

  typedef struct packed {
    logic [ACT_W-1:0] activation;
    logic             sum_saturated;
  } grbf_out_t;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MS_MAG = 3'd0,  // mag * mag
    MS_UU  = 3'd1,  // u * u
    MS_PU  = 3'd2,  // (prod >> 31) * u
    MS_D6  = 3'd3,  // (u3 >> 1) * RECIP3
    MS_D24 = 3'd4,  // (u4 >> 3) * RECIP3
    MS_PP  = 3'd5   // p * p
  } grbf_mul_sel_t;

  typedef struct packed {
    logic          load_in;
    logic          mul_en;
    grbf_mul_sel_t mul_sel;
    logic          div_load;
    logic          div_step;
    logic          acc;
    logic          exp_u;
    logic          cap_u2;
    logic          cap_u3;
    logic          cap_u4;
    logic          cap_t6;
    logic          poly;
    logic          sq_rnd;
    logic          out_load;
  } grbf_cmd_t;

  typedef struct packed {
    logic last;
    logic underflow;
    logic out_free;
  } grbf_status_t;

endpackage

// ===== hw/rtl/gaussian_rbf_activation.sv =====
// ----------------------------------------------------------------------------
// gaussian_rbf_activation
// Gaussian radial basis activation over a vector fed one dimension per
// transaction; emits exp(-sum/2) in Q1.16 after the last dimension.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-----------------------
//  item     | in        | item_valid / item_ready     | grbf_in_t  (x, c, var,
//           |           |                             |             last_dim)
//  result   | out       | result_valid / result_ready | grbf_out_t (activation,
//           |           |                             |             sum_saturated)
//
//  Per dimension: capture, square, divide (two quotient bits per step),
//    accumulate; the last dimension adds the exp sequence, all on the one
//    shared 32x32 multiplier, or skips the series and squaring on underflow.
//  One transaction is worked on at a time; item_ready is high only when idle.
//  The result register lets the next vector start while a result waits;
//    the block holds before loading a new result until the old one is taken.
//  Reset (rst, synchronous) clears the sum, the saturation flag and the
//    result valid; no clearing pass.
// ----------------------------------------------------------------------------
module gaussian_rbf_activation #(
  parameter int FRAC_BITS = grbf_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  grbf_pkg::grbf_in_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output grbf_pkg::grbf_out_t result
);
  import grbf_pkg::*;

  // command and status between sequencer and datapath
  grbf_cmd_t    cmd;
  grbf_status_t status;

  grbf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath holds the running sum, divider, exp registers and result reg
  grbf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== hw/rtl/grbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// grbf_ctrl
// Sequencer: item capture, square, divide, accumulate, then the exp sequence on
// the last dimension and the result load.
// ----------------------------------------------------------------------------
module grbf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  grbf_pkg::grbf_status_t status,
  output grbf_pkg::grbf_cmd_t    cmd
);
  import grbf_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_SQR  = 14'b00000000000010,
    S_DIV  = 14'b00000000000100,
    S_ACC  = 14'b00000000001000,
    S_EXPU = 14'b00000000010000,
    S_M1   = 14'b00000000100000,
    S_M2   = 14'b00000001000000,
    S_M3   = 14'b00000010000000,
    S_M4   = 14'b00000100000000,
    S_M5   = 14'b00001000000000,
    S_POLY = 14'b00010000000000,
    S_SQM  = 14'b00100000000000,
    S_RND  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } grbf_state_t;

  grbf_state_t      state, state_next;
  logic [CTR_W-1:0] ctr, ctr_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctr_next   = ctr;
    cmd        = '0;
    cmd.mul_sel = MS_MAG;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SQR;
        end
      end
      S_SQR: begin
        cmd.mul_sel  = MS_MAG;
        cmd.div_load = 1'b1;
        ctr_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        ctr_next     = ctr + 1'b1;
        if (ctr == CTR_W'(DIV_STEPS - 1)) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.last ? S_EXPU : S_IDLE;
      end
      S_EXPU: begin
        cmd.exp_u  = 1'b1;
        state_next = status.underflow ? S_OUT : S_M1;
      end
      S_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_UU;
        state_next  = S_M2;
      end
      S_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PU;
        cmd.cap_u2  = 1'b1;
        state_next  = S_M3;
      end
      S_M3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PU;
        cmd.cap_u3  = 1'b1;
        state_next  = S_M4;
      end
      S_M4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_D6;
        cmd.cap_u4  = 1'b1;
        state_next  = S_M5;
      end
      S_M5: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_D24;
        cmd.cap_t6  = 1'b1;
        state_next  = S_POLY;
      end
      S_POLY: begin
        cmd.poly   = 1'b1;
        ctr_next   = '0;
        state_next = S_SQM;
      end
      S_SQM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PP;
        state_next  = S_RND;
      end
      S_RND: begin
        cmd.sq_rnd = 1'b1;
        ctr_next   = ctr + 1'b1;
        state_next = (ctr == CTR_W'(SQUARINGS - 1)) ? S_OUT : S_SQM;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctr   <= '0;
    end else begin
      state <= state_next;
      ctr   <= ctr_next;
    end
  end

endmodule

// ===== hw/rtl/grbf_datapath.sv =====
// ----------------------------------------------------------------------------
// grbf_datapath
// Squared difference, two-bit-per-cycle divider, saturating sum, series exp
// with repeated squaring, and the result register.
// ----------------------------------------------------------------------------
module grbf_datapath #(
  parameter int FRAC_BITS = grbf_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  grbf_pkg::grbf_in_t     item,
  input  grbf_pkg::grbf_cmd_t    cmd,
  output grbf_pkg::grbf_status_t status,
  output logic                   result_valid,
  input  logic                   result_ready,
  output grbf_pkg::grbf_out_t    result
);
  import grbf_pkg::*;

  localparam int UW_W = FRAC_BITS + 36;
  localparam logic [SUM_W-1:0] EXP_LIMIT = SUM_W'(24) << FRAC_BITS;

  // captured item
  logic [FIELD_W-1:0] mag;
  logic [FIELD_W-1:0] var_r;
  logic               last;

  // divider
  logic [FIELD_W-1:0] rem;
  logic [SUM_W-1:0]   quo;

  // accumulator
  logic [SUM_W-1:0] sum;
  logic             sat;

  // exp
  logic [26:0] u;
  logic [22:0] u2;
  logic [18:0] u3;
  logic [14:0] u4;
  logic [16:0] t6;
  logic [31:0] p;
  logic        zero_act;
  logic [63:0] prod;

  // ---- input capture ----
  logic signed [FIELD_W:0] diff;
  logic        [FIELD_W:0] diff_abs;
  assign diff     = {item.x_value[FIELD_W-1], item.x_value}
                  - {item.center_value[FIELD_W-1], item.center_value};
  assign diff_abs = diff[FIELD_W] ? (~diff + 1'b1) : diff;

  // ---- shared multiplier ----
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_out;

  always_comb begin
    case (cmd.mul_sel)
      MS_MAG: begin
        mul_a = {8'd0, mag};
        mul_b = {8'd0, mag};
      end
      MS_UU: begin
        mul_a = {5'd0, u};
        mul_b = {5'd0, u};
      end
      MS_PU: begin
        mul_a = prod[62:31];
        mul_b = {5'd0, u};
      end
      MS_D6: begin
        mul_a = {14'd0, u3[18:1]};
        mul_b = RECIP3;
      end
      MS_D24: begin
        mul_a = {20'd0, u4[14:3]};
        mul_b = RECIP3;
      end
      MS_PP: begin
        mul_a = p;
        mul_b = p;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // ---- divider: two restoring steps per cycle ----
  logic [FIELD_W:0]   r1, r2;
  logic               ge1, ge2;
  logic [FIELD_W-1:0] r1s, r2s;

  always_comb begin
    r1  = {rem, quo[SUM_W-1]};
    ge1 = (r1 >= {1'b0, var_r});
    r1s = ge1 ? FIELD_W'(r1 - {1'b0, var_r}) : r1[FIELD_W-1:0];
    r2  = {r1s, quo[SUM_W-2]};
    ge2 = (r2 >= {1'b0, var_r});
    r2s = ge2 ? FIELD_W'(r2 - {1'b0, var_r}) : r2[FIELD_W-1:0];
  end

  // ---- accumulate ----
  logic [SUM_W:0] sum_add;
  assign sum_add = {1'b0, sum} + {1'b0, quo};

  // ---- exp helpers ----
  logic [UW_W-1:0] u_wide;
  logic [32:0]     p_poly;
  logic [63:0]     p_rnd;
  logic [32:0]     act_rnd;
  logic [ACT_W-1:0] act;

  assign u_wide = {sum[FRAC_BITS+4:0], 31'd0} >> (FRAC_BITS + 9);
  assign p_poly = {1'b0, ONE_Q31} - {6'd0, u} + {11'd0, u2[22:1]}
                - {16'd0, t6} + {21'd0, prod[31:RECIP_SHIFT]};
  assign p_rnd   = prod + 64'h0000_0000_4000_0000;
  assign act_rnd = {1'b0, p} + 33'h0_0000_4000;
  assign act     = (act_rnd[32:15] > {1'b0, ONE_OUT}) ? ONE_OUT
                                                      : act_rnd[31:15];

  assign status.last      = last;
  assign status.underflow = (sum >= EXP_LIMIT);
  assign status.out_free  = !result_valid || result_ready;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mag   <= diff_abs[FIELD_W-1:0];
      var_r <= (item.variance == '0) ? FIELD_W'(1) : item.variance;
      last  <= item.last_dim;
    end
    if (cmd.div_load) begin
      quo <= mul_out[SUM_W-1:0];
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_W-3:0], ge1, ge2};
      rem <= r2s;
    end
    if (cmd.mul_en) begin
      prod <= mul_out;
    end
    if (cmd.exp_u) begin
      u        <= u_wide[26:0];
      zero_act <= (sum >= EXP_LIMIT);
    end
    if (cmd.cap_u2) u2 <= prod[53:31];
    if (cmd.cap_u3) u3 <= prod[49:31];
    if (cmd.cap_u4) u4 <= prod[45:31];
    if (cmd.cap_t6) t6 <= prod[36:RECIP_SHIFT];
    if (cmd.poly) begin
      p <= p_poly[31:0];
    end else if (cmd.sq_rnd) begin
      p <= p_rnd[62:31];
    end
    if (cmd.out_load) begin
      result.activation    <= zero_act ? '0 : act;
      result.sum_saturated <= sat;
    end
  end

  // control state: running sum, flag, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      sat          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.acc) begin
        if (sum_add[SUM_W]) begin
          sum <= '1;
          sat <= 1'b1;
        end else begin
          sum <= sum_add[SUM_W-1:0];
        end
      end else if (cmd.out_load) begin
        sum <= '0;
        sat <= 1'b0;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
